/* rtl/ili_pkg.sv */
package ili_pkg;

  // list geometry
  localparam int LIST_CAPACITY = 64;
  localparam int IDX_W         = 7;
  localparam int DATA_W        = 32;
  localparam int LEN_W         = 7;

  // answer for a read outside the list
  localparam logic signed [DATA_W-1:0] READ_INVALID = '1;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_APPEND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
  } rsp_t;

  // port strobes between sequencer and entry memory
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_SHIFT_INS,
    S_INS_FINAL,
    S_SHIFT_DEL,
    S_DONE
  } state_t;

endpackage

/* rtl/indexed_list_insert_delete.sv */
// channel    signals                          beat contents
// request    req_valid / req_ready / req      op, index, value
// response   rsp_valid / rsp_ready / rsp      status, read_value, length
//
// one item at a time; from accept: refused EXEC, DONE; read EXEC, READ_WAIT,
//   DONE; insert/append EXEC, SHIFT_INS per entry moved, INS_FINAL, DONE; delete
//   EXEC, SHIFT_DEL per entry moved, DONE; one write port moves one per cycle
// rst is synchronous: list length clears, entries stay undefined until written
// a held response does not block acceptance of the next request beat
module indexed_list_insert_delete #(
  parameter int CAPACITY = ili_pkg::LIST_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ili_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ili_pkg::rsp_t rsp
);
  import ili_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  mem_ctl_t                 mem_ctl;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] rdata;

  // sequencer
  ili_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // entry storage
  ili_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

/* rtl/ili_mem.sv */
module ili_mem #(
  parameter int DEPTH = ili_pkg::LIST_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  ili_pkg::mem_ctl_t                ctl,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [ili_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [ili_pkg::DATA_W-1:0] rdata
);
  import ili_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ili_ctrl.sv */
module ili_ctrl #(
  parameter int CAPACITY = ili_pkg::LIST_CAPACITY,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  ili_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output ili_pkg::rsp_t                     rsp,
  output ili_pkg::mem_ctl_t                 mem_ctl,
  output logic [AW-1:0]                     waddr,
  output logic signed [ili_pkg::DATA_W-1:0] wdata,
  output logic [AW-1:0]                     raddr,
  input  logic signed [ili_pkg::DATA_W-1:0] rdata
);
  import ili_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  state_t                   state;
  state_t                   state_next;
  req_t                     item;
  logic [CW-1:0]            count;
  logic [AW-1:0]            wptr;
  status_t                  status_r;
  logic signed [DATA_W-1:0] rdval;

  logic [CMPW-1:0] idx_c;
  logic [CMPW-1:0] cnt_c;
  logic [CMPW-1:0] wp_c;
  logic            rd_ok;
  logic            ins_range;
  logic            full;
  logic            del_last_exec;
  logic            last_ins;
  logic            last_del;
  logic            out_free;

  // comparisons at a common width
  assign idx_c         = CMPW'(item.index);
  assign cnt_c         = CMPW'(count);
  assign wp_c          = CMPW'(wptr);
  assign rd_ok         = idx_c < cnt_c;
  assign ins_range     = idx_c > cnt_c;
  assign full          = cnt_c == CMPW'(CAPACITY);
  assign del_last_exec = (idx_c + CMPW'(1)) == cnt_c;
  assign last_ins      = wp_c == (idx_c + CMPW'(1));
  assign last_del      = (wp_c + CMPW'(2)) == cnt_c;
  assign out_free      = !rsp_valid || rsp_ready;

  assign req_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (item.op)
          OP_READ: begin
            state_next = rd_ok ? S_READ_WAIT : S_DONE;
          end
          OP_INSERT: begin
            if (ins_range || full) state_next = S_DONE;
            else if (idx_c == cnt_c) state_next = S_INS_FINAL;
            else state_next = S_SHIFT_INS;
          end
          OP_DELETE: begin
            if (!rd_ok || del_last_exec) state_next = S_DONE;
            else state_next = S_SHIFT_DEL;
          end
          OP_APPEND: begin
            state_next = full ? S_DONE : S_INS_FINAL;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_READ_WAIT: state_next = S_DONE;
      S_SHIFT_INS: begin
        if (last_ins) state_next = S_INS_FINAL;
      end
      S_INS_FINAL: state_next = S_DONE;
      S_SHIFT_DEL: begin
        if (last_del) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    mem_ctl = '0;
    waddr   = wptr;
    wdata   = rdata;
    raddr   = '0;
    case (state)
      S_EXEC: begin
        case (item.op)
          OP_READ: begin
            mem_ctl.re = rd_ok;
            raddr      = idx_c[AW-1:0];
          end
          OP_INSERT: begin
            mem_ctl.re = !ins_range && !full && (idx_c != cnt_c);
            raddr      = AW'(cnt_c - CMPW'(1));
          end
          OP_DELETE: begin
            mem_ctl.re = rd_ok && !del_last_exec;
            raddr      = AW'(idx_c + CMPW'(1));
          end
          default: mem_ctl.re = 1'b0;
        endcase
      end
      S_SHIFT_INS: begin
        // move the entry below up by one, fetch the next one down
        mem_ctl.we = 1'b1;
        mem_ctl.re = !last_ins;
        raddr      = AW'(wp_c - CMPW'(2));
      end
      S_INS_FINAL: begin
        mem_ctl.we = 1'b1;
        wdata      = item.value;
      end
      S_SHIFT_DEL: begin
        // move the entry above down by one, fetch the next one up
        mem_ctl.we = 1'b1;
        mem_ctl.re = !last_del;
        raddr      = AW'(wp_c + CMPW'(2));
      end
      default: mem_ctl = '0;
    endcase
  end

  // state, length and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_INS_FINAL: count <= count + CW'(1);
        S_EXEC: begin
          if (item.op == OP_DELETE && rd_ok && del_last_exec) count <= count - CW'(1);
        end
        S_SHIFT_DEL: begin
          if (last_del) count <= count - CW'(1);
        end
        default: count <= count;
      endcase
    end
  end

  // item payload, working pointer, status and response fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) item <= req;
      end
      S_EXEC: begin
        rdval <= (item.op == OP_READ && !rd_ok) ? READ_INVALID : '0;
        case (item.op)
          OP_READ: status_r <= rd_ok ? ST_DONE : ST_RANGE;
          OP_INSERT: begin
            if (ins_range) status_r <= ST_RANGE;
            else if (full) status_r <= ST_FULL;
            else begin
              status_r <= ST_DONE;
              wptr     <= (idx_c == cnt_c) ? idx_c[AW-1:0] : cnt_c[AW-1:0];
            end
          end
          OP_DELETE: begin
            if (!rd_ok) status_r <= ST_RANGE;
            else begin
              status_r <= ST_DONE;
              wptr     <= idx_c[AW-1:0];
            end
          end
          OP_APPEND: begin
            if (full) status_r <= ST_FULL;
            else begin
              status_r <= ST_DONE;
              wptr     <= cnt_c[AW-1:0];
            end
          end
          default: status_r <= ST_DONE;
        endcase
      end
      S_READ_WAIT: rdval <= rdata;
      S_SHIFT_INS: wptr <= wptr - AW'(1);
      S_SHIFT_DEL: wptr <= wptr + AW'(1);
      S_DONE: begin
        if (out_free) begin
          rsp.status     <= status_r;
          rsp.read_value <= rdval;
          rsp.length     <= LEN_W'(count);
        end
      end
      default: wptr <= wptr;
    endcase
  end

endmodule

/* rtl/ili_check.sv */
module ili_check #(
  parameter int CAPACITY = ili_pkg::LIST_CAPACITY
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ili_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ili_pkg::rsp_t rsp
);
  import ili_pkg::*;

  // no response beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled request beat holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // a full refusal only at full length
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.length == LEN_W'(CAPACITY))
    else $error("full status below capacity");

  // a full refusal returns a zero read value
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.read_value == '0)
    else $error("nonzero read value on refused write");

endmodule

bind indexed_list_insert_delete ili_check #(.CAPACITY(CAPACITY)) u_check (.*);

/* verif/indexed_list_insert_delete_tb.sv */
`timescale 1ns / 100ps

module indexed_list_insert_delete_tb;
  import ili_pkg::*;

  localparam int TARGET_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 100;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  // shadow copy of the list
  logic signed [DATA_W-1:0] shadow_cells [LIST_CAPACITY];
  int                       shadow_len;
  rsp_t                     pending_rsp_q [$];

  int  error_count;
  int  sent_count;
  int  answered_count;
  int  cycle_count;
  int  op_seen [4];
  int  range_seen;
  int  full_seen;
  int  deepest_len;
  bit  steady_mode;
  int  rsp_stall_left;

  indexed_list_insert_delete #(
    .CAPACITY (LIST_CAPACITY)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(6, 40);
  endfunction

  // data values leaning on the extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // apply one operation to the shadow list and return the answer it gives
  function automatic rsp_t apply_list_op(op_t op, int pos, logic signed [DATA_W-1:0] val);
    rsp_t r;
    int   i;
    r.status     = ST_DONE;
    r.read_value = '0;
    case (op)
      OP_READ: begin
        if (pos < shadow_len) begin
          r.read_value = shadow_cells[pos];
        end else begin
          r.status     = ST_RANGE;
          r.read_value = READ_INVALID;
        end
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (pos > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (shadow_len >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_cells[shadow_len] = val;
          shadow_len++;
        end
      end
    endcase
    r.length = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // send one request beat and record what it should produce
  task automatic send_item(op_t op, int pos, logic signed [DATA_W-1:0] val);
    int   gap;
    rsp_t want;
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{op: op, index: pos[IDX_W-1:0], value: val};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = apply_list_op(op, pos, val);
    pending_rsp_q.push_back(want);
    op_seen[op]++;
    sent_count++;
    if (want.status == ST_RANGE) range_seen++;
    if (want.status == ST_FULL) full_seen++;
    if (shadow_len > deepest_len) deepest_len = shadow_len;
  endtask

  // sender holds off until every answer is back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // response side stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready      <= 1'b0;
      rsp_stall_left <= 0;
    end else if (steady_mode) begin
      rsp_ready <= 1'b1;
    end else if (rsp_stall_left > 0) begin
      rsp_stall_left <= rsp_stall_left - 1;
      rsp_ready      <= 1'b0;
    end else begin
      rsp_stall_left <= pick_gap();
      rsp_ready      <= 1'b1;
    end
  end

  // compare each response beat with the oldest pending answer
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin : check_rsp
      rsp_t want;
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("response beat with nothing pending, length", rsp.length, 0);
      end else begin
        want = pending_rsp_q.pop_front();
        answered_count++;
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.read_value !== want.read_value)
          report_mismatch("read_value", rsp.read_value, want.read_value);
        if (rsp.length !== want.length)
          report_mismatch("length", rsp.length, want.length);
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending", cycle_count,
               pending_rsp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // empty list, the value extremes, head, middle and tail positions
  task automatic test_directed_edges();
    send_item(OP_READ,   0, 0);
    send_item(OP_DELETE, 0, 0);
    send_item(OP_INSERT, 1, 32'sh1111_1111);
    send_item(OP_READ,   LIST_CAPACITY, 0);
    send_item(OP_INSERT, 0, 32'sh7FFF_FFFF);
    send_item(OP_APPEND, 99, 32'sh8000_0000);
    send_item(OP_INSERT, 0, -32'sd1);
    send_item(OP_INSERT, 1, 32'sh55AA_33CC);
    send_item(OP_INSERT, 4, 32'sh1234_5678);
    send_item(OP_READ,   0, 32'sh7FFF_FFFF);
    send_item(OP_READ,   4, 0);
    send_item(OP_READ,   5, 0);
    send_item(OP_DELETE, 5, 0);
    send_item(OP_DELETE, 2, 0);
    send_item(OP_DELETE, 0, 0);
    send_item(OP_DELETE, 2, 0);
    send_item(OP_APPEND, 0, 0);
    send_item(OP_READ,   2, 0);
    send_item(OP_INSERT, LIST_CAPACITY, 32'sh0F0F_0F0F);
    send_item(OP_DELETE, LIST_CAPACITY, 0);
    wait_for_drain();
  endtask

  // grow to capacity, probe the full list, then empty it again
  task automatic test_fill_and_overflow();
    steady_mode = 1'b1;
    while (shadow_len < LIST_CAPACITY) begin
      if (shadow_len == LIST_CAPACITY / 2) steady_mode = 1'b0;
      if ($urandom_range(1)) send_item(OP_APPEND, $urandom_range(0, 127), pick_value());
      else send_item(OP_INSERT, $urandom_range(0, shadow_len), pick_value());
    end
    send_item(OP_APPEND, 0, pick_value());
    send_item(OP_INSERT, 0, pick_value());
    send_item(OP_INSERT, LIST_CAPACITY, pick_value());
    send_item(OP_READ,   LIST_CAPACITY - 1, 0);
    send_item(OP_READ,   LIST_CAPACITY, 0);
    send_item(OP_DELETE, LIST_CAPACITY, 0);
    send_item(OP_DELETE, LIST_CAPACITY - 1, 0);
    send_item(OP_INSERT, LIST_CAPACITY, pick_value());
    wait_for_drain();
    while (shadow_len > 0) begin
      if ($urandom_range(3) == 0) send_item(OP_READ, $urandom_range(0, shadow_len - 1), 0);
      else send_item(OP_DELETE, $urandom_range(0, shadow_len - 1), pick_value());
    end
    wait_for_drain();
  endtask

  // bursts that grow, shrink or poke at random positions
  task automatic test_random_mix();
    int mode;
    int burst;
    int r;
    int pos;
    op_t op;
    while (sent_count < TARGET_ITEMS) begin
      mode        = $urandom_range(0, 9);
      burst       = $urandom_range(10, 40);
      steady_mode = ($urandom_range(0, 4) == 0);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (mode < 4) begin
          // growing
          if (r < 45) op = OP_INSERT;
          else if (r < 80) op = OP_APPEND;
          else if (r < 90) op = OP_READ;
          else op = OP_DELETE;
        end else if (mode < 8) begin
          // shrinking
          if (r < 60) op = OP_DELETE;
          else if (r < 80) op = OP_READ;
          else op = OP_INSERT;
        end else begin
          op = op_t'($urandom_range(0, 3));
        end
        if (mode >= 8 || $urandom_range(0, 9) == 0) pos = $urandom_range(0, LIST_CAPACITY);
        else if (op == OP_INSERT) pos = $urandom_range(0, shadow_len);
        else if (shadow_len > 0) pos = $urandom_range(0, shadow_len - 1);
        else pos = $urandom_range(0, LIST_CAPACITY);
        send_item(op, pos, pick_value());
      end
      if ($urandom_range(0, 4) == 0) wait_for_drain();
    end
    steady_mode = 1'b0;
  endtask

  initial begin
    error_count = 0;
    sent_count  = 0;
    shadow_len  = 0;
    steady_mode = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_fill_and_overflow();
    test_random_mix();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d list operations: %0d reads, %0d inserts, %0d deletes, %0d appends",
             sent_count, op_seen[OP_READ], op_seen[OP_INSERT], op_seen[OP_DELETE],
             op_seen[OP_APPEND]);
    $display("%0d refused out of range, %0d refused on a full list, longest list %0d",
             range_seen, full_seen, deepest_len);
    if (error_count == 0 && pending_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d answers never came", error_count, pending_rsp_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* indexed_list_insert_delete.f */
rtl/ili_pkg.sv
rtl/ili_mem.sv
rtl/ili_ctrl.sv
rtl/indexed_list_insert_delete.sv
rtl/ili_check.sv
verif/indexed_list_insert_delete_tb.sv
